// ===== hdl/lowest_free_node_allocator_unit_defines.svh =====
`ifndef LOWEST_FREE_NODE_ALLOCATOR_UNIT_DEFINES_SVH
`define LOWEST_FREE_NODE_ALLOCATOR_UNIT_DEFINES_SVH

// plain check, sampled on clk, off during reset
`define LFNA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication in the same cycle
`define LFNA_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/lfna_pkg.sv =====
`default_nettype none

package lfna_pkg;

  localparam int DEF_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/lowest_free_node_allocator_unit.sv =====
`default_nettype none

`include "lowest_free_node_allocator_unit_defines.svh"

// Node allocator over a used bitmap kept in a one-port-read, one-port-write
// memory of 32-bit words (read data registered). One item is in work at a
// time. A free or an allocate at the high-water mark reads its bitmap word,
// then updates it as needed and goes to the response state; a full or
// out-of-range request goes to the response state at once. An allocate of
// the recorded lowest free node also reads one further bitmap word for
// every word scanned below the mark; the scan takes one word per cycle
// through the memory read port. The response state waits while the result
// register is held by a stalled receiver. Words are cleared by a fill count
// instead of a clearing pass, so the block is ready right after reset.
module lowest_free_node_allocator_unit #(
  parameter int NODES = lfna_pkg::DEF_NODES
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           in_op,
  input  wire  [lfna_pkg::NODE_W-1:0]   in_node_index,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [lfna_pkg::NODE_W-1:0]   out_granted_node,
  output logic [lfna_pkg::STATUS_W-1:0] out_status
);
  import lfna_pkg::*;

  localparam int WORDS = (NODES + WORD_W - 1) / WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NW    = $clog2(NODES + 1);
  localparam int CW    = WAW + BIT_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_GROW  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [NW-1:0]       lf_r, lf_nxt;
  logic [NW-1:0]       hw_r, hw_nxt;
  logic [WAW:0]        touched_r, touched_nxt;
  logic [CW-1:0]       node_r, node_nxt;
  logic [WAW-1:0]      cur_w_r, cur_w_nxt;
  logic [NODE_W-1:0]   res_node_r, res_node_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_node_r, out_node_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [WORD_W-1:0]   mem [WORDS];
  logic [WORD_W-1:0]   rdata_r;
  logic                rd_live_r;
  logic                rd_en;
  logic [WAW-1:0]      rd_addr;
  logic                wr_en;
  logic [WAW-1:0]      wr_addr;
  logic [WORD_W-1:0]   wr_data;

  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   allow;
  logic [WORD_W-1:0]   avail;
  logic [WORD_W-1:0]   lsb;
  logic [BIT_W-1:0]    hit_idx;
  logic                hit;
  logic [CW-1:0]       floor_c;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       next_base;
  logic [CW-1:0]       node_in;
  logic [CW-1:0]       lf_tmp;
  logic [CW-1:0]       hw_tmp;
  logic [WORD_W-1:0]   bit_sel;
  logic                out_free;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_node = out_node_r;
  assign out_status       = out_status_r;
  assign out_free         = !out_valid_r || !out_stall;

  // bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_live_r <= ({1'b0, rd_addr} < touched_r);
    end
  end

  assign word    = rd_live_r ? rdata_r : '0;
  assign node_in = CW'(in_node_index);
  assign bit_sel = WORD_W'(1) << node_r[BIT_W-1:0];

  // free bits of the current word between floor and high-water mark
  always_comb begin
    floor_c = (state_r == S_ALLOC) ? node_r + CW'(1) : '0;
    allow   = '0;
    pos     = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos      = CW'({cur_w_r, BIT_W'(j)});
      allow[j] = (pos >= floor_c) && (pos < CW'(hw_r));
    end
    avail   = ~word & allow;
    lsb     = avail & (~avail + WORD_W'(1));
    hit     = |avail;
    hit_idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (((j >> k) & 1) == 1) begin
          hit_idx[k] = hit_idx[k] | lsb[j];
        end
      end
    end
  end

  assign next_base = CW'({({1'b0, cur_w_r} + (WAW + 1)'(1)), BIT_W'(0)});

  always_comb begin
    state_nxt      = state_r;
    lf_nxt         = lf_r;
    hw_nxt         = hw_r;
    touched_nxt    = touched_r;
    node_nxt       = node_r;
    cur_w_nxt      = cur_w_r;
    res_node_nxt   = res_node_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_node_nxt   = out_node_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = cur_w_r;
    wr_en          = 1'b0;
    wr_addr        = cur_w_r;
    wr_data        = word | bit_sel;
    lf_tmp         = CW'(lf_r);
    hw_tmp         = CW'(hw_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_node_nxt   = '0;
          res_status_nxt = ST_DONE;
          if (in_op == OP_FREE) begin
            if (node_in < CW'(NODES)) begin
              node_nxt  = node_in;
              cur_w_nxt = WAW'(node_in >> BIT_W);
              rd_en     = 1'b1;
              rd_addr   = WAW'(node_in >> BIT_W);
              state_nxt = S_FREE;
            end else begin
              res_status_nxt = ST_NOT_USED;
              state_nxt      = S_RESP;
            end
          end else if (lf_r < hw_r) begin
            node_nxt  = CW'(lf_r);
            cur_w_nxt = WAW'(lf_r >> BIT_W);
            rd_en     = 1'b1;
            rd_addr   = WAW'(lf_r >> BIT_W);
            state_nxt = S_ALLOC;
          end else if (hw_r < NW'(NODES)) begin
            node_nxt  = CW'(hw_r);
            cur_w_nxt = WAW'(hw_r >> BIT_W);
            rd_en     = 1'b1;
            rd_addr   = WAW'(hw_r >> BIT_W);
            state_nxt = S_GROW;
          end else begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end
        end
      end
      S_FREE: begin
        state_nxt = S_RESP;
        if ((word & bit_sel) == '0) begin
          res_status_nxt = ST_NOT_USED;
        end else begin
          wr_en   = 1'b1;
          wr_data = word & ~bit_sel;
          if (node_r < lf_tmp) begin
            lf_tmp = node_r;
          end
          if ((hw_tmp != '0) && (node_r == hw_tmp - CW'(1))) begin
            hw_tmp = hw_tmp - CW'(1);
            if (lf_tmp >= hw_tmp) begin
              lf_tmp = CW'(NODES);
            end
          end
          lf_nxt = NW'(lf_tmp);
          hw_nxt = NW'(hw_tmp);
        end
      end
      S_GROW: begin
        wr_en        = 1'b1;
        hw_nxt       = hw_r + NW'(1);
        res_node_nxt = NODE_W'(node_r);
        state_nxt    = S_RESP;
      end
      S_ALLOC, S_SCAN: begin
        if (state_r == S_ALLOC) begin
          wr_en        = 1'b1;
          res_node_nxt = NODE_W'(node_r);
        end
        if (hit) begin
          lf_nxt    = NW'({cur_w_r, hit_idx});
          state_nxt = S_RESP;
        end else if (next_base < CW'(hw_r)) begin
          rd_en     = 1'b1;
          rd_addr   = WAW'(cur_w_r + WAW'(1));
          cur_w_nxt = WAW'(cur_w_r + WAW'(1));
          state_nxt = S_SCAN;
        end else begin
          lf_nxt    = NW'(NODES);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = res_node_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en && ({1'b0, wr_addr} == touched_r)) begin
      touched_nxt = touched_r + (WAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lf_r        <= NW'(NODES);
      hw_r        <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lf_r        <= lf_nxt;
      hw_r        <= hw_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    cur_w_r      <= cur_w_nxt;
    res_node_r   <= res_node_nxt;
    res_status_r <= res_status_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
  end

  `LFNA_CHECK(a_hw_range, hw_r <= NW'(NODES), "high-water mark beyond table")
  `LFNA_CHECK(a_lf_below_hw, (lf_r == NW'(NODES)) || (lf_r < hw_r), "lowest free not below mark")
  `LFNA_IMPLY(a_no_idle_write, state_r == S_IDLE, !wr_en, "bitmap write while idle")
  `LFNA_IMPLY(a_out_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP, "word without response")

endmodule

`default_nettype wire

// ===== sim/lfna_alloc_tracker.sv =====
`timescale 1ns / 100ps

module lfna_alloc_tracker #(
  parameter int NODES = lfna_pkg::DEF_NODES
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  wire                              in_op,
  input  wire  [lfna_pkg::NODE_W-1:0]      in_node_index,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  wire  [lfna_pkg::NODE_W-1:0]      out_granted_node,
  input  wire  [lfna_pkg::STATUS_W-1:0]    out_status,
  output int                               error_count,
  output int                               pending_words,
  output int                               grants,
  output int                               full_answers,
  output int                               ignored_frees,
  output logic [NODES-1:0]                 used_nodes,
  output logic [$clog2(NODES+1)-1:0]       mark
);
  import lfna_pkg::*;

  localparam int MARK_W = $clog2(NODES + 1);
  localparam logic [MARK_W-1:0] NONE_REC = MARK_W'(NODES);

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic [NODES-1:0]  used_map = '0;
  logic [MARK_W-1:0] low_free = NONE_REC;
  logic [MARK_W-1:0] high_mark = '0;
  grant_t            expected_grants[$];
  int                errs = 0;
  int                n_grants = 0;
  int                n_full = 0;
  int                n_ignored = 0;

  function automatic grant_t apply_request(input logic op, input logic [NODE_W-1:0] idx);
    grant_t r;
    int     i;
    int     take;
    r.node   = '0;
    r.status = ST_DONE;
    if (op == OP_ALLOC) begin
      if (low_free < high_mark && low_free < NODES) begin
        take = int'(low_free);
        r.node = low_free[NODE_W-1:0];
        used_map[take] = 1'b1;
        low_free = NONE_REC;
        for (i = take + 1; i < int'(high_mark) && i < NODES; i++) begin
          if (!used_map[i]) begin
            low_free = MARK_W'(i);
            break;
          end
        end
        n_grants++;
      end else if (high_mark < NODES) begin
        r.node = high_mark[NODE_W-1:0];
        used_map[high_mark] = 1'b1;
        high_mark = high_mark + 1'b1;
        n_grants++;
      end else begin
        r.status = ST_FULL;
        n_full++;
      end
    end else begin
      if (idx >= NODES || !used_map[idx]) begin
        r.status = ST_NOT_USED;
        n_ignored++;
      end else begin
        used_map[idx] = 1'b0;
        if (idx < low_free) low_free = MARK_W'(idx);
        if (high_mark > 0 && idx == high_mark - 1) begin
          high_mark = high_mark - 1'b1;
          if (low_free >= high_mark) low_free = NONE_REC;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t exp_word;
    if (!rst_n) begin
      used_map = '0;
      low_free = NONE_REC;
      high_mark = '0;
      expected_grants.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected word: out_granted_node %0d, out_status %0d",
                 out_granted_node, out_status);
          errs++;
        end else begin
          exp_word = expected_grants.pop_front();
          if (out_granted_node !== exp_word.node) begin
            $error("out_granted_node mismatch: expected %0d, actual %0d",
                   exp_word.node, out_granted_node);
            errs++;
          end
          if (out_status !== exp_word.status) begin
            $error("out_status mismatch: expected %0d, actual %0d",
                   exp_word.status, out_status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) expected_grants.push_back(apply_request(in_op, in_node_index));
    end
    error_count   <= errs;
    pending_words <= expected_grants.size();
    grants        <= n_grants;
    full_answers  <= n_full;
    ignored_frees <= n_ignored;
    used_nodes    <= used_map;
    mark          <= high_mark;
  end

endmodule

// ===== sim/lowest_free_node_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module lowest_free_node_allocator_unit_tb;
  import lfna_pkg::*;

  localparam int MARK_W      = $clog2(DEF_NODES + 1);
  localparam int QUIET_LIMIT = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_op = OP_ALLOC;
  logic [NODE_W-1:0]   in_node_index = '0;
  logic                out_stall = 1'b0;
  wire                 in_stall;
  wire                 out_valid;
  wire  [NODE_W-1:0]   out_granted_node;
  wire  [STATUS_W-1:0] out_status;

  int                  tracker_errors;
  int                  pending_words;
  int                  grants;
  int                  full_answers;
  int                  ignored_frees;
  logic [DEF_NODES-1:0] used_nodes;
  logic [MARK_W-1:0]   mark;

  int                  words_sent = 0;
  int                  burst_left = 0;
  int                  quiet_cycles = 0;
  int                  cycle_no = 0;
  int                  stall_mode = 0;
  int                  stall_left = 0;
  logic [MARK_W-1:0]   peak_mark = '0;

  lowest_free_node_allocator_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_node (out_granted_node),
    .out_status       (out_status)
  );

  lfna_alloc_tracker tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_node (out_granted_node),
    .out_status       (out_status),
    .error_count      (tracker_errors),
    .pending_words    (pending_words),
    .grants           (grants),
    .full_answers     (full_answers),
    .ignored_frees    (ignored_frees),
    .used_nodes       (used_nodes),
    .mark             (mark)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern, switched now and then at random
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 2) != 0);
      default: out_stall <= cycle_no[2];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (mark > peak_mark) peak_mark <= mark;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [NODE_W-1:0] idx);
    int gap;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_node_index <= idx;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // mostly nodes in use below the mark, so frees usually take effect
  function automatic logic [NODE_W-1:0] pick_used();
    int                k;
    logic [NODE_W-1:0] n;
    n = NODE_W'($urandom_range(0, DEF_NODES - 1));
    if (mark == 0) return n;
    for (k = 0; k < 8; k++) begin
      n = NODE_W'($urandom_range(0, mark - 1));
      if (used_nodes[n]) return n;
    end
    return n;
  endfunction

  task automatic send_random(input int alloc_pct);
    int sel;
    sel = $urandom_range(0, 9);
    if ($urandom_range(1, 100) <= alloc_pct) begin
      send_word(OP_ALLOC, NODE_W'($urandom_range(0, DEF_NODES - 1)));
    end else if (sel < 6) begin
      send_word(OP_FREE, pick_used());
    end else if (sel < 8 && mark != 0) begin
      send_word(OP_FREE, NODE_W'(mark - 1'b1));
    end else begin
      send_word(OP_FREE, NODE_W'($urandom_range(0, DEF_NODES - 1)));
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, hole tracking, mark drops
    send_word(OP_FREE, 10'd0);
    send_word(OP_FREE, 10'd1023);
    send_word(OP_ALLOC, 10'd1023);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_ALLOC, 10'd682);
    send_word(OP_ALLOC, 10'd341);
    send_word(OP_FREE, 10'd1);
    send_word(OP_FREE, 10'd2);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_FREE, 10'd3);
    send_word(OP_FREE, 10'd3);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_FREE, 10'd0);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_FREE, 10'd3);
    send_word(OP_FREE, 10'd2);
    send_word(OP_ALLOC, 10'd0);
    send_word(OP_FREE, 10'd682);
    send_word(OP_FREE, 10'd341);
    wait_drained();

    for (k = 0; k < 20; k++) send_random(50);
    wait_drained();

    // fill up to the top and keep hitting the full table
    while (full_answers < 6) send_random(99);

    // holes across the whole table force long scans
    for (k = 0; k < 40; k++) send_random(45);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d words: %0d grants, %0d full answers, %0d ignored frees",
             words_sent, grants, full_answers, ignored_frees);
    $display("highest mark reached %0d of %0d nodes", peak_mark, DEF_NODES);
    if (tracker_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
